[sv/alm_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Array linked list manager package
// Sizes, operation and status codes, and the result record used by the
// manager; its channel interfaces and its port checker use the sizes too.
// ---------------------------------------------------------------------------
package alm_pkg;

  localparam int SLOTS        = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int LINK_W       = $clog2(SLOTS + 1);
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [LINK_W-1:0]       link_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;

  // A link equal to the slot count marks the end of the list.
  localparam link_t END_LINK = LINK_W'(SLOTS);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_FIRST = 3'd0,
    KIND_ADD_AFTER = 3'd1,
    KIND_ADD_LAST  = 3'd2,
    KIND_DEL_FIRST = 3'd3,
    KIND_DEL_AFTER = 3'd4,
    KIND_DEL_LAST  = 3'd5,
    KIND_DEL_ALL   = 3'd6,
    KIND_TRAVERSE  = 3'd7
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef struct packed {
    status_e  status;
    slot_t    slot;
    payload_t payload;
    logic     last;
  } result_t;

endpackage
`default_nettype wire

[sv/alm_in_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Array linked list manager request channel
// Valid/ready channel that carries one list operation per transfer.
// ---------------------------------------------------------------------------
interface alm_in_if;

  logic                          valid;
  logic                          ready;
  logic [alm_pkg::KIND_W-1:0]    kind;
  logic [alm_pkg::SLOT_W-1:0]    prev_slot;
  logic [alm_pkg::PAYLOAD_BITS-1:0] payload;

  modport source (output valid, kind, prev_slot, payload, input ready);
  modport sink   (input valid, kind, prev_slot, payload, output ready);

endinterface
`default_nettype wire

[sv/alm_out_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Array linked list manager result channel
// Valid/ready channel that carries one result record per transfer.
// ---------------------------------------------------------------------------
interface alm_out_if;

  logic                             valid;
  logic                             ready;
  logic [alm_pkg::STATUS_W-1:0]     status;
  logic [alm_pkg::SLOT_W-1:0]       slot;
  logic [alm_pkg::PAYLOAD_BITS-1:0] payload_out;
  logic [alm_pkg::CNT_W-1:0]        count;
  logic                             last;

  modport source (output valid, status, slot, payload_out, count, last, input ready);
  modport sink   (input valid, status, slot, payload_out, count, last, output ready);

endinterface
`default_nettype wire

[sv/array_linked_list_manager.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Array linked list manager
// Singly linked list kept in a fixed slot store, driven by a small sequencer
// around one read port of the link and payload memories.
// ---------------------------------------------------------------------------
// The block takes one operation at a time and is not ready until it has
// finished with it. The walk to the tail follows one link per cycle, and
// delete all walks from the head to the current tail for each removal.
// While the result register cannot be emptied, the block waits to emit.
// Results leave through an output register, so a new operation is taken
// while the last result of the previous one still waits. No clearing pass
// runs after reset.
// ---------------------------------------------------------------------------
module array_linked_list_manager (
  input  logic      clk_i,
  input  logic      rst_ni,
  alm_in_if.sink    in_i,
  alm_out_if.source out_o
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DISPATCH = 13'b0000000000010,
    S_RD       = 13'b0000000000100,
    S_WALK     = 13'b0000000001000,
    S_INS_HEAD = 13'b0000000010000,
    S_INS_NEW  = 13'b0000000100000,
    S_INS_PREV = 13'b0000001000000,
    S_DH_RM    = 13'b0000010000000,
    S_DA_CHK   = 13'b0000100000000,
    S_DA_RM    = 13'b0001000000000,
    S_TAIL_RM  = 13'b0010000000000,
    S_TR_CHK   = 13'b0100000000000,
    S_EMIT     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // List control state.
  alm_pkg::slot_t              head_q, head_d;
  alm_pkg::count_t             count_q, count_d;
  logic [alm_pkg::SLOTS-1:0]   used_q, used_d;
  alm_pkg::slot_t              free_q, free_d;

  // Captured request and walk registers.
  alm_pkg::kind_e              kind_q, kind_d;
  alm_pkg::slot_t              prev_q, prev_d;
  alm_pkg::payload_t           pay_q, pay_d;
  alm_pkg::slot_t              cur_q, cur_d;
  alm_pkg::slot_t              pred_q, pred_d;
  logic                        pred_vld_q, pred_vld_d;
  alm_pkg::slot_t              new_q, new_d;
  alm_pkg::result_t            stg_q, stg_d;

  // Output register.
  logic                        out_vld_q, out_vld_d;
  alm_pkg::result_t            out_q, out_d;
  alm_pkg::count_t             out_cnt_q, out_cnt_d;

  // Link and payload memories with one read address and one write address, each shared by both.
  alm_pkg::link_t              link_mem [alm_pkg::SLOTS];
  alm_pkg::payload_t           pay_mem  [alm_pkg::SLOTS];
  alm_pkg::link_t              link_rd_q;
  alm_pkg::payload_t           pay_rd_q;
  alm_pkg::slot_t              rd_addr;
  logic                        link_we;
  logic                        pay_we;
  alm_pkg::slot_t              wr_addr;
  alm_pkg::link_t              link_wd;

  logic                        can_push;
  logic                        is_full;
  logic                        is_empty;
  logic                        rd_end;
  alm_pkg::slot_t              rd_next;
  alm_pkg::count_t             cnt_dec;
  alm_pkg::count_t             cnt_inc;

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_q.status;
  assign out_o.slot        = out_q.slot;
  assign out_o.payload_out = out_q.payload;
  assign out_o.count       = out_cnt_q;
  assign out_o.last        = out_q.last;

  assign can_push = !out_vld_q || out_o.ready;
  assign is_full  = (count_q >= alm_pkg::CNT_W'(alm_pkg::SLOTS));
  assign is_empty = (count_q == '0);
  assign rd_end   = (link_rd_q >= alm_pkg::END_LINK);
  assign rd_next  = link_rd_q[alm_pkg::SLOT_W-1:0];
  assign cnt_dec  = alm_pkg::CNT_W'(count_q - alm_pkg::CNT_W'(1));
  assign cnt_inc  = alm_pkg::CNT_W'(count_q + alm_pkg::CNT_W'(1));

  // Lowest free slot, registered; it is only used by an operation after the
  // one that last changed the used bits.
  always_comb begin
    free_d = '0;
    for (int i = alm_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_d = alm_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    used_d     = used_q;
    kind_d     = kind_q;
    prev_d     = prev_q;
    pay_d      = pay_q;
    cur_d      = cur_q;
    pred_d     = pred_q;
    pred_vld_d = pred_vld_q;
    new_d      = new_q;
    stg_d      = stg_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_d      = out_q;
    out_cnt_d  = out_cnt_q;
    rd_addr    = cur_q;
    link_we    = 1'b0;
    pay_we     = 1'b0;
    wr_addr    = free_q;
    link_wd    = alm_pkg::END_LINK;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d  = alm_pkg::kind_e'(in_i.kind);
          prev_d  = in_i.prev_slot;
          pay_d   = in_i.payload;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        // Error results carry slot 0 and payload 0.
        stg_d   = '{status: alm_pkg::ST_OK, slot: '0, payload: '0, last: 1'b1};
        state_d = S_EMIT;
        unique case (kind_q) inside
          alm_pkg::KIND_ADD_FIRST: begin
            if (is_full) begin
              stg_d.status = alm_pkg::ST_FULL;
            end else begin
              state_d = S_INS_HEAD;
            end
          end
          alm_pkg::KIND_ADD_AFTER: begin
            if (is_full) begin
              stg_d.status = alm_pkg::ST_FULL;
            end else if (!used_q[prev_q]) begin
              stg_d.status = alm_pkg::ST_BADPOS;
            end else begin
              cur_d   = prev_q;
              state_d = S_RD;
            end
          end
          alm_pkg::KIND_ADD_LAST: begin
            if (is_empty) begin
              state_d = S_INS_HEAD;
            end else if (is_full) begin
              stg_d.status = alm_pkg::ST_FULL;
            end else begin
              cur_d      = head_q;
              pred_vld_d = 1'b0;
              state_d    = S_RD;
            end
          end
          alm_pkg::KIND_DEL_FIRST, alm_pkg::KIND_TRAVERSE: begin
            if (is_empty) begin
              stg_d.status = alm_pkg::ST_EMPTY;
            end else begin
              cur_d   = head_q;
              state_d = S_RD;
            end
          end
          alm_pkg::KIND_DEL_AFTER: begin
            if (is_empty) begin
              stg_d.status = alm_pkg::ST_EMPTY;
            end else if (!used_q[prev_q]) begin
              stg_d.status = alm_pkg::ST_BADPOS;
            end else begin
              cur_d   = prev_q;
              state_d = S_RD;
            end
          end
          alm_pkg::KIND_DEL_LAST, alm_pkg::KIND_DEL_ALL: begin
            // Delete all on an empty list reports a single ok result.
            if (is_empty) begin
              if (kind_q == alm_pkg::KIND_DEL_LAST) begin
                stg_d.status = alm_pkg::ST_EMPTY;
              end
            end else begin
              cur_d      = head_q;
              pred_vld_d = 1'b0;
              state_d    = S_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_RD: begin
        unique case (kind_q) inside
          alm_pkg::KIND_ADD_AFTER:                                              state_d = S_INS_NEW;
          alm_pkg::KIND_ADD_LAST, alm_pkg::KIND_DEL_LAST, alm_pkg::KIND_DEL_ALL: state_d = S_WALK;
          alm_pkg::KIND_DEL_FIRST:                                              state_d = S_DH_RM;
          alm_pkg::KIND_DEL_AFTER:                                              state_d = S_DA_CHK;
          alm_pkg::KIND_TRAVERSE:                                               state_d = S_TR_CHK;
          default:                                                              state_d = S_IDLE;
        endcase
      end

      S_WALK: begin
        // One link per cycle: the next read address comes straight from
        // the link just read.
        if (!rd_end) begin
          pred_d     = cur_q;
          pred_vld_d = 1'b1;
          cur_d      = rd_next;
          rd_addr    = rd_next;
        end else if (kind_q == alm_pkg::KIND_ADD_LAST) begin
          state_d = S_INS_NEW;
        end else begin
          state_d = S_TAIL_RM;
        end
      end

      S_INS_HEAD: begin
        link_we         = 1'b1;
        pay_we          = 1'b1;
        link_wd         = is_empty ? alm_pkg::END_LINK : alm_pkg::LINK_W'(head_q);
        used_d[free_q]  = 1'b1;
        count_d         = cnt_inc;
        head_d          = free_q;
        stg_d           = '{status: alm_pkg::ST_OK, slot: free_q, payload: '0, last: 1'b1};
        state_d         = S_EMIT;
      end

      S_INS_NEW: begin
        // The new slot inherits the successor of the slot in cur.
        link_we         = 1'b1;
        pay_we          = 1'b1;
        link_wd         = link_rd_q;
        used_d[free_q]  = 1'b1;
        count_d         = cnt_inc;
        new_d           = free_q;
        state_d         = S_INS_PREV;
      end

      S_INS_PREV: begin
        link_we = 1'b1;
        wr_addr = cur_q;
        link_wd = alm_pkg::LINK_W'(new_q);
        stg_d   = '{status: alm_pkg::ST_OK, slot: new_q, payload: '0, last: 1'b1};
        state_d = S_EMIT;
      end

      S_DH_RM: begin
        head_d        = rd_end ? '0 : rd_next;
        used_d[cur_q] = 1'b0;
        count_d       = cnt_dec;
        if (cnt_dec == '0) begin
          head_d = '0;
        end
        stg_d   = '{status: alm_pkg::ST_OK, slot: cur_q, payload: pay_rd_q, last: 1'b1};
        state_d = S_EMIT;
      end

      S_DA_CHK: begin
        if (rd_end) begin
          stg_d   = '{status: alm_pkg::ST_BADPOS, slot: '0, payload: '0, last: 1'b1};
          state_d = S_EMIT;
        end else begin
          new_d   = rd_next;
          rd_addr = rd_next;
          state_d = S_DA_RM;
        end
      end

      S_DA_RM: begin
        // Unlink the victim held in new: its predecessor takes its link.
        link_we       = 1'b1;
        wr_addr       = cur_q;
        link_wd       = link_rd_q;
        used_d[new_q] = 1'b0;
        count_d       = cnt_dec;
        if (cnt_dec == '0) begin
          head_d = '0;
        end
        stg_d   = '{status: alm_pkg::ST_OK, slot: new_q, payload: pay_rd_q, last: 1'b1};
        state_d = S_EMIT;
      end

      S_TAIL_RM: begin
        if (pred_vld_q) begin
          link_we = 1'b1;
          wr_addr = pred_q;
          link_wd = alm_pkg::END_LINK;
        end else begin
          head_d = '0;
        end
        used_d[cur_q] = 1'b0;
        count_d       = cnt_dec;
        if (cnt_dec == '0) begin
          head_d = '0;
        end
        stg_d = '{status: alm_pkg::ST_OK, slot: cur_q, payload: pay_rd_q,
                  last: (kind_q == alm_pkg::KIND_DEL_LAST) || (cnt_dec == '0)};
        state_d = S_EMIT;
      end

      S_TR_CHK: begin
        stg_d   = '{status: alm_pkg::ST_OK, slot: cur_q, payload: pay_rd_q, last: rd_end};
        cur_d   = rd_next;
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (can_push) begin
          out_vld_d = 1'b1;
          out_d     = stg_q;
          out_cnt_d = count_q;
          if (stg_q.last) begin
            state_d = S_IDLE;
          end else begin
            // Delete all restarts its walk from the head for the next tail;
            // traverse continues at the successor already in cur.
            if (kind_q == alm_pkg::KIND_DEL_ALL) begin
              cur_d      = head_q;
              pred_vld_d = 1'b0;
            end
            state_d = S_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_q     <= free_d;
    kind_q     <= kind_d;
    prev_q     <= prev_d;
    pay_q      <= pay_d;
    cur_q      <= cur_d;
    pred_q     <= pred_d;
    pred_vld_q <= pred_vld_d;
    new_q      <= new_d;
    stg_q      <= stg_d;
    out_q      <= out_d;
    out_cnt_q  <= out_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[wr_addr] <= link_wd;
    end
    if (pay_we) begin
      pay_mem[wr_addr] <= pay_q;
    end
    link_rd_q <= link_mem[rd_addr];
    pay_rd_q  <= pay_mem[rd_addr];
  end

endmodule
`default_nettype wire

[sv/alm_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Array linked list manager port checker
// Watches the request and result channels of the manager over time.
// ---------------------------------------------------------------------------
module alm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [alm_pkg::STATUS_W-1:0]     out_status_i,
  input logic [alm_pkg::SLOT_W-1:0]       out_slot_i,
  input logic [alm_pkg::PAYLOAD_BITS-1:0] out_payload_i,
  input logic [alm_pkg::CNT_W-1:0]        out_count_i,
  input logic                             out_last_i
);

  // A request transfer keeps the block busy for at least the next cycle.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while the previous one was still being accepted");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i <= alm_pkg::CNT_W'(alm_pkg::SLOTS))
    else $error("element count above the slot count");

  // Error results are single results without slot or payload.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != alm_pkg::ST_OK) |->
      out_last_i && (out_slot_i == '0) && (out_payload_i == '0))
    else $error("error result is not a clean final result");

  // While a multi-result operation is still producing, no request is taken.
  a_busy_mid_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("ready for a request before the last result was produced");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_status_i, out_slot_i, out_payload_i, out_count_i, out_last_i}))
    else $error("stalled result changed or dropped");

endmodule

bind array_linked_list_manager alm_checker u_alm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_slot_i    (out_o.slot),
  .out_payload_i (out_o.payload_out),
  .out_count_i   (out_o.count),
  .out_last_i    (out_o.last)
);
`default_nettype wire

[tb/array_linked_list_manager_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
// ---------------------------------------------------------------------------
// Array linked list manager result checker
// Watches the request and result channels of the manager, keeps its own copy
// of the slot store to work out the results of every accepted operation, and
// compares each result transfer, field by field, with the oldest one due.
// ---------------------------------------------------------------------------
module array_linked_list_manager_checker
  import alm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  alm_in_if    op_mon_i,
  alm_out_if   reply_mon_i,
  output int   errors_o,
  output int   outstanding_o
);

  typedef struct packed {
    status_e  status;
    slot_t    slot;
    payload_t payload;
    count_t   count;
    logic     last;
  } list_reply_t;

  slot_t            head_q;
  count_t           size_q;
  logic [SLOTS-1:0] occupied;
  link_t            next_mem [SLOTS];
  payload_t         data_mem [SLOTS];
  list_reply_t      replies_due [$];

  // The count field always carries the element count after the change.
  function automatic void queue_reply(status_e st, slot_t s, payload_t p, logic fin);
    list_reply_t r;
    r.status  = st;
    r.slot    = s;
    r.payload = p;
    r.count   = size_q;
    r.last    = fin;
    replies_due.push_back(r);
  endfunction

  function automatic slot_t claim_slot(payload_t p);
    slot_t s;
    s = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!occupied[i]) s = slot_t'(i);
    end
    occupied[s] = 1'b1;
    data_mem[s] = p;
    size_q++;
    return s;
  endfunction

  function automatic void free_slot(slot_t s);
    occupied[s] = 1'b0;
    if (size_q != 0) size_q--;
    if (size_q == 0) head_q = '0;
  endfunction

  function automatic void insert_at_head(payload_t p);
    slot_t s;
    if (size_q >= SLOTS) begin
      queue_reply(ST_FULL, '0, '0, 1'b1);
    end else begin
      s = claim_slot(p);
      next_mem[s] = (size_q == 1) ? END_LINK : link_t'(head_q);
      head_q = s;
      queue_reply(ST_OK, s, '0, 1'b1);
    end
  endfunction

  // The full check is made before the position check.
  function automatic void insert_behind(slot_t prev, payload_t p);
    slot_t s;
    if (size_q >= SLOTS) begin
      queue_reply(ST_FULL, '0, '0, 1'b1);
    end else if (!occupied[prev]) begin
      queue_reply(ST_BADPOS, '0, '0, 1'b1);
    end else begin
      s = claim_slot(p);
      next_mem[s] = next_mem[prev];
      next_mem[prev] = link_t'(s);
      queue_reply(ST_OK, s, '0, 1'b1);
    end
  endfunction

  // Returns the tail; pred is END_LINK when the tail is also the head.
  function automatic link_t locate_tail(output link_t pred);
    link_t cur;
    int    steps;
    cur   = link_t'(head_q);
    pred  = END_LINK;
    steps = 0;
    while (steps < SLOTS && cur < END_LINK && next_mem[slot_t'(cur)] < END_LINK) begin
      pred = cur;
      cur  = next_mem[slot_t'(cur)];
      steps++;
    end
    return cur;
  endfunction

  function automatic slot_t unlink_head();
    slot_t r;
    link_t nx;
    r  = head_q;
    nx = next_mem[r];
    head_q = (nx < END_LINK) ? slot_t'(nx) : '0;
    free_slot(r);
    return r;
  endfunction

  function automatic slot_t unlink_behind(slot_t prev);
    slot_t r;
    r = slot_t'(next_mem[prev]);
    next_mem[prev] = next_mem[r];
    free_slot(r);
    return r;
  endfunction

  function automatic slot_t unlink_tail();
    link_t pred;
    void'(locate_tail(pred));
    if (pred >= END_LINK) return unlink_head();
    return unlink_behind(slot_t'(pred));
  endfunction

  function automatic void apply_op(kind_e kind, slot_t prev, payload_t p);
    slot_t r;
    link_t tail;
    link_t pred;
    link_t walk;
    link_t nx;
    int    k;
    case (kind)
      KIND_ADD_FIRST: insert_at_head(p);
      KIND_ADD_AFTER: insert_behind(prev, p);
      KIND_ADD_LAST: begin
        if (size_q == 0) begin
          insert_at_head(p);
        end else if (size_q >= SLOTS) begin
          queue_reply(ST_FULL, '0, '0, 1'b1);
        end else begin
          tail = locate_tail(pred);
          insert_behind(slot_t'(tail), p);
        end
      end
      KIND_DEL_FIRST: begin
        if (size_q == 0) begin
          queue_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          r = unlink_head();
          queue_reply(ST_OK, r, data_mem[r], 1'b1);
        end
      end
      KIND_DEL_AFTER: begin
        if (size_q == 0) begin
          queue_reply(ST_EMPTY, '0, '0, 1'b1);
        end else if (!occupied[prev] || next_mem[prev] >= END_LINK) begin
          queue_reply(ST_BADPOS, '0, '0, 1'b1);
        end else begin
          r = unlink_behind(prev);
          queue_reply(ST_OK, r, data_mem[r], 1'b1);
        end
      end
      KIND_DEL_LAST: begin
        if (size_q == 0) begin
          queue_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          r = unlink_tail();
          queue_reply(ST_OK, r, data_mem[r], 1'b1);
        end
      end
      KIND_DEL_ALL: begin
        // Clearing an empty list still answers once, with status ok.
        if (size_q == 0) begin
          queue_reply(ST_OK, '0, '0, 1'b1);
        end else begin
          k = 0;
          while (size_q != 0 && k < SLOTS) begin
            r = unlink_tail();
            queue_reply(ST_OK, r, data_mem[r], size_q == 0 || k + 1 >= SLOTS);
            k++;
          end
        end
      end
      KIND_TRAVERSE: begin
        if (size_q == 0) begin
          queue_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          walk = link_t'(head_q);
          k = 0;
          while (walk < END_LINK && k < SLOTS) begin
            nx = next_mem[slot_t'(walk)];
            queue_reply(ST_OK, slot_t'(walk), data_mem[slot_t'(walk)],
                        nx >= END_LINK || k + 1 >= SLOTS);
            walk = nx;
            k++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    errors_o++;
    $display("%0t result check: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    if (!rst_ni) begin
      head_q   = '0;
      size_q   = '0;
      occupied = '0;
      replies_due.delete();
      errors_o = 0;
      outstanding_o <= 0;
    end else begin
      // A result leaving at this edge always belongs to an earlier operation,
      // so it is checked before the operation taken at the same edge.
      if (reply_mon_i.valid && reply_mon_i.ready) begin
        if (replies_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result, status %0d slot %0d",
                                  reply_mon_i.status, reply_mon_i.slot));
        end else begin
          want = replies_due.pop_front();
          if (reply_mon_i.status !== want.status)
            note_mismatch($sformatf("status %0d, expected %0d",
                                    reply_mon_i.status, want.status));
          if (reply_mon_i.slot !== want.slot)
            note_mismatch($sformatf("slot %0d, expected %0d", reply_mon_i.slot, want.slot));
          if (reply_mon_i.payload_out !== want.payload)
            note_mismatch($sformatf("payload %h, expected %h",
                                    reply_mon_i.payload_out, want.payload));
          if (reply_mon_i.count !== want.count)
            note_mismatch($sformatf("count %0d, expected %0d", reply_mon_i.count, want.count));
          if (reply_mon_i.last !== want.last)
            note_mismatch($sformatf("last %b, expected %b", reply_mon_i.last, want.last));
        end
      end
      if (op_mon_i.valid && op_mon_i.ready)
        apply_op(kind_e'(op_mon_i.kind), op_mon_i.prev_slot, op_mon_i.payload);
      outstanding_o <= replies_due.size();
    end
  end

endmodule
`default_nettype wire

[tb/array_linked_list_manager_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
// ---------------------------------------------------------------------------
// Array linked list manager testbench
// Drives list operations into the manager, first a directed sweep of the
// empty, bad position and full cases, then random runs of growing, shrinking
// and mixed traffic, with random stalls on both channels. The checker beside
// the block predicts and compares every result; this module gives the verdict.
// ---------------------------------------------------------------------------
module array_linked_list_manager_tb;
  import alm_pkg::*;

  localparam int     RANDOM_OPS    = 190;
  localparam int     CALM_OPS      = 40;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     SETTLE_CYCLES = 250;
  localparam longint TIMEOUT_NS    = 10_000_000;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_ANY,
    MIX_NOISE
  } op_mix_e;

  logic clk;
  logic rst_n;
  bit   long_hold;
  bit   calm;
  int   burst_free;
  int   mismatches;
  int   pending;

  alm_in_if  op_ch ();
  alm_out_if reply_ch ();

  array_linked_list_manager dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (op_ch),
    .out_o  (reply_ch)
  );

  array_linked_list_manager_checker u_list_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .op_mon_i      (op_ch),
    .reply_mon_i   (reply_ch),
    .errors_o      (mismatches),
    .outstanding_o (pending)
  );

  initial clk = 1'b0;

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("array_linked_list_manager: mismatch");
    $finish;
  end

  // Result side: random ready pattern, one long hold-off on request, and a
  // steady ready once the calm stretch at the end has begun.
  initial begin
    bit hold_done;
    hold_done      = 1'b0;
    reply_ch.ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        reply_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        reply_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        reply_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Offers one operation and returns at the edge of its transfer. A gap with
  // junk on the idle fields may come first.
  task automatic issue(input kind_e kind, input slot_t prev, input payload_t pay);
    if (burst_free > 0) begin
      burst_free--;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      op_ch.valid     <= 1'b0;
      op_ch.kind      <= KIND_W'($urandom);
      op_ch.prev_slot <= SLOT_W'($urandom);
      op_ch.payload   <= $urandom;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    op_ch.valid     <= 1'b1;
    op_ch.kind      <= kind;
    op_ch.prev_slot <= prev;
    op_ch.payload   <= pay;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    op_mix_e mix;
    int      left_in_mix;
    int      roll;
    kind_e   kind;
    slot_t   prev;

    rst_n           = 1'b0;
    long_hold       = 1'b0;
    calm            = 1'b0;
    burst_free      = 0;
    op_ch.valid     = 1'b0;
    op_ch.kind      = '0;
    op_ch.prev_slot = '0;
    op_ch.payload   = '0;
    mix             = MIX_GROW;
    left_in_mix     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Traverse, every delete and an insert after a slot, all on an empty list.
    issue(KIND_TRAVERSE, 4'd0, '0);
    issue(KIND_DEL_FIRST, 4'd0, '0);
    issue(KIND_DEL_AFTER, 4'd15, '0);
    issue(KIND_DEL_LAST, 4'd0, '0);
    issue(KIND_DEL_ALL, 4'd0, '0);
    issue(KIND_ADD_AFTER, 4'd0, 32'h1234_5678);
    // Add at the tail of an empty list, then build 1 -> 0 -> 2.
    issue(KIND_ADD_LAST, 4'd0, '1);
    issue(KIND_ADD_FIRST, 4'd15, '0);
    issue(KIND_ADD_AFTER, 4'd15, 32'hDEAD_BEEF);
    issue(KIND_ADD_AFTER, 4'd0, 32'hA5A5_5A5A);
    // Delete after the tail, then after the head.
    issue(KIND_DEL_AFTER, 4'd2, '0);
    issue(KIND_DEL_AFTER, 4'd1, '0);
    // Fill the store, then try to go past it.
    for (int i = 0; i < SLOTS - 2; i++) begin
      issue((i % 3 == 0) ? KIND_ADD_FIRST : (i % 3 == 1) ? KIND_ADD_AFTER : KIND_ADD_LAST,
            4'd1, $urandom);
    end
    issue(KIND_ADD_LAST, 4'd0, $urandom);
    issue(KIND_ADD_AFTER, 4'd1, $urandom);
    issue(KIND_TRAVERSE, 4'd0, '0);
    issue(KIND_DEL_ALL, 4'd0, '0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS - CALM_OPS) calm = 1'b1;
      // Hold results off while operations keep coming so the block backs up.
      if (n == 70) begin
        long_hold  = 1'b1;
        burst_free = 12;
      end
      if (n == 140) drain();
      if (left_in_mix == 0) begin
        roll = $urandom_range(0, 9);
        mix  = (roll < 4) ? MIX_GROW : (roll < 7) ? MIX_SHRINK : (roll < 9) ? MIX_ANY : MIX_NOISE;
        left_in_mix = $urandom_range(10, 28);
        if (!calm && $urandom_range(0, 2) == 0) drain();
      end
      left_in_mix--;

      roll = $urandom_range(0, 99);
      case (mix)
        MIX_GROW: begin
          if (roll < 30)      kind = KIND_ADD_FIRST;
          else if (roll < 60) kind = KIND_ADD_AFTER;
          else if (roll < 85) kind = KIND_ADD_LAST;
          else if (roll < 90) kind = KIND_DEL_FIRST;
          else if (roll < 94) kind = KIND_DEL_AFTER;
          else if (roll < 98) kind = KIND_TRAVERSE;
          else                kind = KIND_DEL_LAST;
        end
        MIX_SHRINK: begin
          if (roll < 25)      kind = KIND_DEL_FIRST;
          else if (roll < 50) kind = KIND_DEL_AFTER;
          else if (roll < 75) kind = KIND_DEL_LAST;
          else if (roll < 80) kind = KIND_DEL_ALL;
          else if (roll < 90) kind = KIND_TRAVERSE;
          else                kind = KIND_ADD_LAST;
        end
        default: kind = kind_e'($urandom_range(0, 7));
      endcase
      // Inserts take the lowest free slot, so low slot numbers are mostly
      // in the list and make the best positions.
      if (mix == MIX_NOISE) prev = SLOT_W'($urandom_range(0, 15));
      else                  prev = SLOT_W'($urandom_range(0, $urandom_range(0, 15)));
      issue(kind, prev, $urandom);
    end

    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("array_linked_list_manager: match");
    end else begin
      $display("array_linked_list_manager: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
sv/alm_pkg.sv
sv/alm_in_if.sv
sv/alm_out_if.sv
sv/array_linked_list_manager.sv
sv/alm_checker.sv
tb/array_linked_list_manager_checker.sv
tb/array_linked_list_manager_tb.sv
